[rtl/core/bpfa_pkg.sv]
// shared types, codes and widths for the bitmap page frame allocator
package bpfa_pkg;

   // field widths
   localparam int CMD_BITS       = 3;
   localparam int ADDR_BITS      = 48;
   localparam int LEN_BITS       = 25;
   localparam int RBYTES_BITS    = 25;
   localparam int BMAP_BITS      = 10;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 48;
   localparam int REQ_TDATA_BITS = 80;
   localparam int RSP_TDATA_BITS = 56;

   // shared adder width: 48-bit address plus a 25-bit span plus carry room
   localparam int ALU_BITS = 50;

   // map words
   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = 6;

   // parameter defaults
   localparam int PAGE_BYTES_DEFAULT = 4096;
   localparam int MAX_PAGES_DEFAULT  = 4096;

   // command codes
   typedef enum logic [CMD_BITS-1:0] {
      CMD_ALLOC_ANY     = 3'd0,
      CMD_ALLOC_AT      = 3'd1,
      CMD_FREE          = 3'd2,
      CMD_RESERVE_AT    = 3'd3,
      CMD_RESERVE_RANGE = 3'd4
   } cmd_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MAP_PRESENT  = 2'd0,
      CSR_REGION_BASE  = 2'd1,
      CSR_REGION_BYTES = 2'd2,
      CSR_BITMAP_BYTES = 2'd3
   } csr_index_type;

   // configuration as seen by the sequencer
   typedef struct packed {
      logic                   map_present;
      logic [ADDR_BITS-1:0]   region_base;
      logic [RBYTES_BITS-1:0] region_bytes;
      logic [BMAP_BITS-1:0]   bitmap_bytes;
   } cfg_type;

   // one result, ok in the lowest bit
   typedef struct packed {
      logic [ADDR_BITS-1:0] page_address;
      logic                 ok;
   } rsp_type;

   // map port strobes
   typedef struct packed {
      logic rd;
      logic wr;
   } map_cmd_type;

endpackage

[rtl/core/bpfa_alu.sv]
// shared add / subtract unit used by the sequencer for every address check
module bpfa_alu (
   input  logic [bpfa_pkg::ALU_BITS-1:0] a,
   input  logic [bpfa_pkg::ALU_BITS-1:0] b,
   input  logic                          sub,
   output logic [bpfa_pkg::ALU_BITS-1:0] sum,
   output logic                          carry
);

   logic [bpfa_pkg::ALU_BITS-1:0] b_op;

   // subtract as a plus inverted b plus one; carry set means a >= b
   assign b_op = sub ? ~b : b;
   assign {carry, sum} = {1'b0, a} + {1'b0, b_op} +
                         {{bpfa_pkg::ALU_BITS{1'b0}}, sub};

endmodule

[rtl/core/bpfa_map.sv]
// page usage map: one 64-bit word per 64 pages, cleared by a sweep after reset
module bpfa_map #(
   parameter int MAX_PAGES = bpfa_pkg::MAX_PAGES_DEFAULT,
   parameter int MAP_WORDS = (MAX_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS,
   parameter int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bpfa_pkg::map_cmd_type          cmd,
   input  logic [WW-1:0]                  addr,
   input  logic [bpfa_pkg::WORD_BITS-1:0] wdata,
   output logic [bpfa_pkg::WORD_BITS-1:0] rdata,
   output logic                           ready
);

   logic [bpfa_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
   logic [bpfa_pkg::WORD_BITS-1:0] rdata_ff;
   logic [WW-1:0]                  clr_ff;
   logic [WW-1:0]                  clr_in;
   logic                           busy_ff;
   logic                           busy_in;

   // clearing sweep, one word a cycle
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (clr_ff == WW'(MAP_WORDS - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_in = clr_ff + WW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // single write port, sweep has priority
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (cmd.wr) begin
         mem[addr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign ready = !busy_ff;

endmodule

[rtl/core/bpfa_ctrl.sv]
// command sequencer: address checks on the shared adder, then a word-at-a-time map walk
module bpfa_ctrl #(
   parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEFAULT,
   parameter int MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEFAULT,
   parameter int MAP_WORDS  = (MAX_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS,
   parameter int WW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bpfa_pkg::cfg_type               cfg,
   // command side
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [bpfa_pkg::CMD_BITS-1:0]   in_cmd,
   input  logic [bpfa_pkg::ADDR_BITS-1:0]  in_addr,
   input  logic [bpfa_pkg::LEN_BITS-1:0]   in_len,
   // result side
   output logic                            out_valid,
   input  logic                            out_ready,
   output bpfa_pkg::rsp_type               out_rsp,
   // map port
   output bpfa_pkg::map_cmd_type           map_cmd,
   output logic [WW-1:0]                   map_addr,
   output logic [bpfa_pkg::WORD_BITS-1:0]  map_wdata,
   input  logic [bpfa_pkg::WORD_BITS-1:0]  map_rdata,
   input  logic                            map_ready,
   // shared adder
   output logic [bpfa_pkg::ALU_BITS-1:0]   alu_a,
   output logic [bpfa_pkg::ALU_BITS-1:0]   alu_b,
   output logic                            alu_sub,
   input  logic [bpfa_pkg::ALU_BITS-1:0]   alu_sum,
   input  logic                            alu_carry
);

   localparam int AW = bpfa_pkg::ALU_BITS;
   localparam int PS = $clog2(PAGE_BYTES);
   localparam int CW = $clog2(MAX_PAGES + bpfa_pkg::WORD_BITS);
   localparam int WB = bpfa_pkg::WORD_BITS;
   localparam int WS = bpfa_pkg::WORD_SHIFT;
   localparam logic [AW-1:0] PAGE_W    = AW'(PAGE_BYTES);
   localparam logic [AW-1:0] PAGE_MASK = ~(AW'(PAGE_BYTES) - AW'(1));
   localparam logic [AW-1:0] MAX_W     = AW'(MAX_PAGES);
   localparam logic [CW-1:0] MAX_C     = CW'(MAX_PAGES);
   localparam logic [CW-1:0] ALIGN_C   = ~CW'(WB - 1);
   localparam logic [CW-1:0] STEP_C    = CW'(WB);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LIM,
      S_LOW,
      S_END,
      S_HICHK,
      S_STOP,
      S_PADIFF,
      S_SPAN,
      S_SETUP,
      S_RD,
      S_PROC,
      S_ADDR,
      S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   bpfa_pkg::cmd_type               cmd_ff, cmd_in;
   logic [bpfa_pkg::ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [bpfa_pkg::LEN_BITS-1:0]   len_ff, len_in;
   logic [AW-1:0]                   lim_ff, lim_in;
   logic [AW-1:0]                   d_ff, d_in;
   logic [AW-1:0]                   t_ff, t_in;
   logic [AW-1:0]                   e_ff, e_in;
   logic                            ge_lo_ff, ge_lo_in;
   logic                            pa_ge_ff, pa_ge_in;
   logic                            hi_ok_ff, hi_ok_in;
   logic [CW-1:0]                   lo_ff, lo_in;
   logic [CW-1:0]                   hi_ff, hi_in;
   logic [CW-1:0]                   cur_ff, cur_in;
   logic [CW-1:0]                   k_ff, k_in;
   logic                            ok_ff, ok_in;
   logic [bpfa_pkg::ADDR_BITS-1:0]  res_ff, res_in;

   logic [WB-1:0]                   mask;
   logic [WB-1:0]                   cand;
   logic [WS-1:0]                   pick;
   logic [CW-1:0]                   cur_next;
   logic [CW-1:0]                   k_one;
   logic                            k_in_map;
   logic [AW-1:0]                   limit_w;
   logic [CW-1:0]                   k0;
   logic [CW-1:0]                   kend;

   // page index of a byte offset, saturated at the map size
   function automatic logic [CW-1:0] clamp_idx(input logic [AW-1:0] v);
      logic [AW-1:0] s;
      s = v >> PS;
      if (s >= MAX_W) begin
         return MAX_C;
      end
      return s[CW-1:0];
   endfunction

   // bits of the word at base whose page index lies in [lo, hi)
   function automatic logic [WB-1:0] range_mask(input logic [CW-1:0] base,
                                                input logic [CW-1:0] lo,
                                                input logic [CW-1:0] hi);
      logic [WB-1:0] m;
      logic [CW-1:0] idx;
      m = '0;
      for (int b = 0; b < WB; b++) begin
         idx  = base + CW'(b);
         m[b] = (idx >= lo) && (idx < hi);
      end
      return m;
   endfunction

   // lowest set bit
   function automatic logic [WS-1:0] lowest_set(input logic [WB-1:0] v);
      logic [WS-1:0] p;
      p = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (v[i]) begin
            p = WS'(i);
         end
      end
      return p;
   endfunction

   // word walk helpers
   assign mask     = range_mask(cur_ff, lo_ff, hi_ff);
   assign cand     = ~map_rdata & mask;
   assign pick     = lowest_set(cand);
   assign cur_next = cur_ff + STEP_C;
   assign k_one    = d_ff[PS +: CW];
   assign k_in_map = (d_ff >> PS) < MAX_W;
   assign limit_w  = AW'(cfg.bitmap_bytes) << 3;
   assign k0       = pa_ge_ff ? clamp_idx(d_ff) : '0;
   assign kend     = clamp_idx(e_ff);

   // handshake and map address
   assign in_ready  = (state_ff == S_IDLE) && map_ready;
   assign out_valid = (state_ff == S_DONE);
   assign out_rsp   = '{page_address: res_ff, ok: ok_ff};
   assign map_addr  = cur_ff[WS +: WW];

   // next-state and datapath
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      len_in    = len_ff;
      lim_in    = lim_ff;
      d_in      = d_ff;
      t_in      = t_ff;
      e_in      = e_ff;
      ge_lo_in  = ge_lo_ff;
      pa_ge_in  = pa_ge_ff;
      hi_ok_in  = hi_ok_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      ok_in     = ok_ff;
      res_in    = res_ff;
      alu_a     = '0;
      alu_b     = '0;
      alu_sub   = 1'b0;
      map_cmd   = '{rd: 1'b0, wr: 1'b0};
      map_wdata = map_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (in_valid && in_ready) begin
               cmd_in  = bpfa_pkg::cmd_type'(in_cmd);
               addr_in = in_addr;
               len_in  = in_len;
               ok_in   = 1'b0;
               res_in  = '0;
               priority case (bpfa_pkg::cmd_type'(in_cmd))
                  bpfa_pkg::CMD_ALLOC_ANY:     state_in = S_SETUP;
                  bpfa_pkg::CMD_ALLOC_AT,
                  bpfa_pkg::CMD_FREE,
                  bpfa_pkg::CMD_RESERVE_AT,
                  bpfa_pkg::CMD_RESERVE_RANGE: state_in = S_LIM;
                  default:                     state_in = S_DONE;
               endcase
            end
         end

         // region end = base + size
         S_LIM: begin
            alu_a    = AW'(cfg.region_base);
            alu_b    = AW'(cfg.region_bytes);
            lim_in   = alu_sum;
            state_in = S_LOW;
         end

         // offset into the region and lower bound check
         S_LOW: begin
            alu_a    = AW'(addr_ff);
            alu_b    = AW'(cfg.region_base);
            alu_sub  = 1'b1;
            d_in     = alu_sum;
            ge_lo_in = alu_carry;
            state_in = (cmd_ff == bpfa_pkg::CMD_FREE) ? S_HICHK : S_END;
         end

         // end of the page or of the span
         S_END: begin
            alu_a    = AW'(addr_ff);
            alu_b    = (cmd_ff == bpfa_pkg::CMD_RESERVE_RANGE) ? AW'(len_ff) : PAGE_W;
            t_in     = alu_sum;
            state_in = S_HICHK;
         end

         // upper bound check
         S_HICHK: begin
            alu_sub = 1'b1;
            if (cmd_ff == bpfa_pkg::CMD_FREE) begin
               alu_a    = AW'(addr_ff);
               alu_b    = lim_ff;
               hi_ok_in = !alu_carry;
            end else begin
               alu_a    = lim_ff;
               alu_b    = t_ff;
               hi_ok_in = alu_carry;
            end
            state_in = (cmd_ff == bpfa_pkg::CMD_RESERVE_RANGE) ? S_STOP : S_SETUP;
         end

         // span end rounded up to a page
         S_STOP: begin
            alu_a    = t_ff;
            alu_b    = PAGE_W - AW'(1);
            t_in     = alu_sum & PAGE_MASK;
            state_in = S_PADIFF;
         end

         // first page offset, may lie below an unaligned base
         S_PADIFF: begin
            alu_a    = AW'(addr_ff) & PAGE_MASK;
            alu_b    = AW'(cfg.region_base);
            alu_sub  = 1'b1;
            d_in     = alu_sum;
            pa_ge_in = alu_carry;
            state_in = S_SPAN;
         end

         // rounded end offset
         S_SPAN: begin
            alu_a    = t_ff;
            alu_b    = AW'(cfg.region_base);
            alu_sub  = 1'b1;
            e_in     = alu_sum;
            state_in = S_SETUP;
         end

         // set up the page index range to walk
         S_SETUP: begin
            state_in = S_DONE;
            unique case (cmd_ff)
               bpfa_pkg::CMD_ALLOC_ANY: begin
                  lo_in  = '0;
                  hi_in  = (limit_w >= MAX_W) ? MAX_C : limit_w[CW-1:0];
                  cur_in = '0;
                  if (cfg.map_present && (limit_w != '0)) begin
                     state_in = S_RD;
                  end
               end
               bpfa_pkg::CMD_ALLOC_AT,
               bpfa_pkg::CMD_FREE,
               bpfa_pkg::CMD_RESERVE_AT: begin
                  lo_in  = k_one;
                  hi_in  = k_one + CW'(1);
                  cur_in = k_one & ALIGN_C;
                  if (cfg.map_present && ge_lo_ff && hi_ok_ff && k_in_map) begin
                     state_in = S_RD;
                  end
               end
               bpfa_pkg::CMD_RESERVE_RANGE: begin
                  lo_in  = k0;
                  hi_in  = kend;
                  cur_in = k0 & ALIGN_C;
                  if (ge_lo_ff && hi_ok_ff) begin
                     ok_in = 1'b1;
                     if (kend > k0) begin
                        state_in = S_RD;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         S_RD: begin
            map_cmd  = '{rd: 1'b1, wr: 1'b0};
            state_in = S_PROC;
         end

         // read-modify-write of one map word
         S_PROC: begin
            state_in = S_DONE;
            unique case (cmd_ff)
               bpfa_pkg::CMD_ALLOC_ANY: begin
                  if (cand != '0) begin
                     map_cmd   = '{rd: 1'b0, wr: 1'b1};
                     map_wdata = map_rdata | (WB'(1) << pick);
                     k_in      = cur_ff + CW'(pick);
                     state_in  = S_ADDR;
                  end else begin
                     cur_in = cur_next;
                     if (cur_next < hi_ff) begin
                        state_in = S_RD;
                     end
                  end
               end
               bpfa_pkg::CMD_ALLOC_AT,
               bpfa_pkg::CMD_RESERVE_AT: begin
                  if ((map_rdata & mask) == '0) begin
                     map_cmd   = '{rd: 1'b0, wr: 1'b1};
                     map_wdata = map_rdata | mask;
                     ok_in     = 1'b1;
                     if (cmd_ff == bpfa_pkg::CMD_ALLOC_AT) begin
                        res_in = addr_ff;
                     end
                  end
               end
               bpfa_pkg::CMD_FREE: begin
                  map_cmd   = '{rd: 1'b0, wr: 1'b1};
                  map_wdata = map_rdata & ~mask;
                  ok_in     = 1'b1;
               end
               bpfa_pkg::CMD_RESERVE_RANGE: begin
                  map_cmd   = '{rd: 1'b0, wr: 1'b1};
                  map_wdata = map_rdata | mask;
                  cur_in    = cur_next;
                  if (cur_next < hi_ff) begin
                     state_in = S_RD;
                  end
               end
               default: begin
               end
            endcase
         end

         // base + index * page size, wrapped to 48 bits
         S_ADDR: begin
            alu_a    = AW'(cfg.region_base);
            alu_b    = AW'(k_ff) << PS;
            res_in   = alu_sum[bpfa_pkg::ADDR_BITS-1:0];
            ok_in    = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      len_ff   <= len_in;
      lim_ff   <= lim_in;
      d_ff     <= d_in;
      t_ff     <= t_in;
      e_ff     <= e_in;
      ge_lo_ff <= ge_lo_in;
      pa_ge_ff <= pa_ge_in;
      hi_ok_ff <= hi_ok_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      cur_ff   <= cur_in;
      k_ff     <= k_in;
      ok_ff    <= ok_in;
      res_ff   <= res_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_wr_only_in_proc: assert property (@(posedge clock) disable iff (reset)
      map_cmd.wr |-> (state_ff == S_PROC))
      else $error("map written outside read-modify-write step");

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (cur_ff < hi_ff))
      else $error("map word read past the end of the walk");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after result transfer");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff != S_IDLE))
      else $error("accepted command was not started");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !map_ready |-> !in_ready)
      else $error("command accepted during map clearing");
`endif

endmodule

[rtl/core/bitmap_page_frame_allocator.sv]
// top level of the bitmap page frame allocator: config registers, result register, core
//
//  channel   dir  handshake                tdata / fields
//  req_      in   req_tvalid / req_tready  command, address, length
//  rsp_      out  rsp_tvalid / rsp_tready  ok, page_address
//  csr_      in   csr_valid / csr_ready    csr_index, csr_data (register write)
//
// After reset the map is swept clear one word a cycle, and no command is taken until then;
// csr writes are taken at any time. Alloc any searches the map a word at a time until a
// free page is found or the search range ends; reserve range marks every map word that its
// span touches, one read-modify-write per word.
// One command in flight; a full output register holds the sequencer in its done step.
module bitmap_page_frame_allocator #(
   parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEFAULT,
   parameter int MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // command stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bpfa_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // command[2:0], address[50:3], length[75:51]
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bpfa_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // ok[0], page_address[48:1]
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bpfa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bpfa_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int MAP_WORDS = (MAX_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
   localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic                                    map_present_ff;
   logic [bpfa_pkg::ADDR_BITS-1:0]          region_base_ff;
   logic [bpfa_pkg::RBYTES_BITS-1:0]        region_bytes_ff;
   logic [bpfa_pkg::BMAP_BITS-1:0]          bitmap_bytes_ff;
   bpfa_pkg::cfg_type                       cfg;

   logic                                    rsp_valid_ff;
   bpfa_pkg::rsp_type                       rsp_data_ff;

   logic                                    core_out_valid;
   logic                                    core_out_ready;
   bpfa_pkg::rsp_type                       core_out_rsp;

   bpfa_pkg::map_cmd_type                   map_cmd;
   logic [WW-1:0]                           map_addr;
   logic [bpfa_pkg::WORD_BITS-1:0]          map_wdata;
   logic [bpfa_pkg::WORD_BITS-1:0]          map_rdata;
   logic                                    map_ready;

   logic [bpfa_pkg::ALU_BITS-1:0]           alu_a;
   logic [bpfa_pkg::ALU_BITS-1:0]           alu_b;
   logic                                    alu_sub;
   logic [bpfa_pkg::ALU_BITS-1:0]           alu_sum;
   logic                                    alu_carry;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_present_ff  <= 1'b0;
         region_base_ff  <= '0;
         region_bytes_ff <= '0;
         bitmap_bytes_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (bpfa_pkg::csr_index_type'(csr_index))
            bpfa_pkg::CSR_MAP_PRESENT:  map_present_ff  <= csr_data[0];
            bpfa_pkg::CSR_REGION_BASE:  region_base_ff  <= csr_data;
            bpfa_pkg::CSR_REGION_BYTES: region_bytes_ff <= csr_data[bpfa_pkg::RBYTES_BITS-1:0];
            bpfa_pkg::CSR_BITMAP_BYTES: bitmap_bytes_ff <= csr_data[bpfa_pkg::BMAP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{map_present:  map_present_ff,
                  region_base:  region_base_ff,
                  region_bytes: region_bytes_ff,
                  bitmap_bytes: bitmap_bytes_ff};

   // result register between core and output stream
   assign core_out_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (core_out_valid && core_out_ready) begin
         rsp_data_ff <= core_out_rsp;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_out_ready) begin
         rsp_valid_ff <= core_out_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bpfa_pkg::RSP_TDATA_BITS'(rsp_data_ff);

   bpfa_alu u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   bpfa_map #(
      .MAX_PAGES (MAX_PAGES),
      .MAP_WORDS (MAP_WORDS),
      .WW        (WW)
   ) u_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .addr  (map_addr),
      .wdata (map_wdata),
      .rdata (map_rdata),
      .ready (map_ready)
   );

   bpfa_ctrl #(
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_PAGES  (MAX_PAGES),
      .MAP_WORDS  (MAP_WORDS),
      .WW         (WW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tdata[2:0]),
      .in_addr   (req_tdata[50:3]),
      .in_len    (req_tdata[75:51]),
      .out_valid (core_out_valid),
      .out_ready (core_out_ready),
      .out_rsp   (core_out_rsp),
      .map_cmd   (map_cmd),
      .map_addr  (map_addr),
      .map_wdata (map_wdata),
      .map_rdata (map_rdata),
      .map_ready (map_ready),
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_sub   (alu_sub),
      .alu_sum   (alu_sum),
      .alu_carry (alu_carry)
   );

endmodule
